FILE: hdl/lfdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfdp_pkg
// Shared types and constants of the latent factor dot product block: the
// payload structs of both channels, the mode codes, the arithmetic widths
// and the configuration register map.
// ----------------------------------------------------------------------------
package lfdp_pkg;

  localparam int FACTOR_W   = 16;
  localparam int PROD_W     = 2 * FACTOR_W;
  localparam int ACC_W      = 48;
  localparam int PRED_W     = 40;
  localparam int RANK_CFG_W = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] MODE_LOAD_USER = 2'd0;
  localparam logic [1:0] MODE_LOAD_ITEM = 2'd1;
  localparam logic [1:0] MODE_QUERY     = 2'd2;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_RANK = 1'b0;

  localparam logic [RANK_CFG_W-1:0] RANK_RESET = 6'd32;

  localparam logic signed [ACC_W-1:0] PRED_MAX = 48'sh00_7F_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] PRED_MIN = 48'shFF_80_0000_0000;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [9:0]                 entity_index;
    logic [4:0]                 dimension_index;
    logic signed [FACTOR_W-1:0] factor_value;
    logic [9:0]                 user_index;
    logic [9:0]                 item_index;
  } in_item_t;

  typedef struct packed {
    logic signed [PRED_W-1:0] prediction;
    logic                     index_error;
  } out_item_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage : lfdp_pkg
`default_nettype wire

FILE: hdl/lfdp_factor_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfdp_factor_ram
// Factor store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lfdp_factor_ram
  import lfdp_pkg::*;
#(
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic signed [FACTOR_W-1:0] wdata,
  input  logic [ADDR_W-1:0]          raddr,
  output logic signed [FACTOR_W-1:0] rdata
);

  logic signed [FACTOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : lfdp_factor_ram
`default_nettype wire

FILE: hdl/lfdp_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfdp_mac
// Shared multiply-accumulate unit: a registered 16x16 product feeding a wide
// exact accumulator, with the saturated 40-bit view of the sum.
// ----------------------------------------------------------------------------
module lfdp_mac
  import lfdp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctrl_t                  ctrl,
  input  logic signed [FACTOR_W-1:0] a,
  input  logic signed [FACTOR_W-1:0] b,
  output logic signed [PRED_W-1:0]   result,
  output logic                       busy
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_comb begin
    if (acc > PRED_MAX) begin
      result = PRED_MAX[PRED_W-1:0];
    end else if (acc < PRED_MIN) begin
      result = PRED_MIN[PRED_W-1:0];
    end else begin
      result = acc[PRED_W-1:0];
    end
  end

  assign busy = prod_valid;

endmodule : lfdp_mac
`default_nettype wire

FILE: hdl/latent_factor_dot_product.sv
`default_nettype none
// ----------------------------------------------------------------------------
// latent_factor_dot_product
// Stores user and item factor vectors and answers each query with the
// saturated dot product of one user vector and one item vector.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               beat
//  in       input      in_valid / in_stall     in_data  (in_item_t)
//  out      output     out_valid / out_stall   out_data (out_item_t)
//  cfg      input      APB psel/penable/pready rank_in_use at byte address 0
//
//  A load beat's element is written at the accept edge. A query steps
//  through one dimension per cycle on the single multiplier, drains the
//  read and product stages and then hands the result over; a query with
//  a bad index or rank zero goes straight to the hand-over.
//  The output register holds a finished result while the next beat comes in.
//  Reset is synchronous; the factor stores are not cleared by it.
// ----------------------------------------------------------------------------
module latent_factor_dot_product
  import lfdp_pkg::*;
#(
  parameter int MAX_USERS = 1024,
  parameter int MAX_ITEMS = 1024,
  parameter int MAX_RANK  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  localparam int U_DEPTH = MAX_USERS * MAX_RANK;
  localparam int I_DEPTH = MAX_ITEMS * MAX_RANK;
  localparam int UA_W    = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
  localparam int IA_W    = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1;
  localparam int K_W     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RANK_W  = $clog2(MAX_RANK + 1);
  localparam int RW      = (RANK_W > RANK_CFG_W) ? RANK_W : RANK_CFG_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                  state;
  logic [RANK_CFG_W-1:0]   rank_in_use;
  logic [RW-1:0]           rank_ext;
  logic [RW-1:0]           rank_eff;
  logic [RW-1:0]           rank_m1;
  logic [K_W-1:0]          k;
  logic [K_W-1:0]          rank_last;
  logic [UA_W-1:0]         ubase;
  logic [IA_W-1:0]         ibase;
  logic                    err;
  logic                    rd_valid;
  logic                    in_accept;
  logic                    cfg_wr;
  logic                    query_err;
  logic                    dim_ok;
  logic                    u_we;
  logic                    i_we;
  logic                    is_query;
  logic                    out_load;
  logic [UA_W-1:0]         u_waddr;
  logic [IA_W-1:0]         i_waddr;
  logic [UA_W-1:0]         u_raddr;
  logic [IA_W-1:0]         i_raddr;
  logic signed [FACTOR_W-1:0] u_rdata;
  logic signed [FACTOR_W-1:0] i_rdata;
  logic signed [PRED_W-1:0]   mac_result;
  logic                    mac_busy;
  mac_ctrl_t               mac_ctrl;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1] == REG_RANK) begin
      prdata = CFG_DATA_W'(rank_in_use);
    end
  end

  // Ranks above the store depth are clamped to it.
  assign rank_ext = RW'(rank_in_use);
  assign rank_eff = (rank_ext > RW'(MAX_RANK)) ? RW'(MAX_RANK) : rank_ext;
  assign rank_m1  = rank_eff - 1'b1;

  assign query_err = (32'(in_data.user_index) >= MAX_USERS) ||
                     (32'(in_data.item_index) >= MAX_ITEMS);
  assign dim_ok    = 32'(in_data.dimension_index) < MAX_RANK;

  assign u_waddr = UA_W'(32'(in_data.entity_index) * 32'(MAX_RANK) +
                         32'(in_data.dimension_index));
  assign i_waddr = IA_W'(32'(in_data.entity_index) * 32'(MAX_RANK) +
                         32'(in_data.dimension_index));

  always_comb begin
    u_we     = 1'b0;
    i_we     = 1'b0;
    is_query = 1'b0;
    if (in_accept) begin
      unique case (in_data.mode)
        MODE_LOAD_USER: begin
          u_we = dim_ok && (32'(in_data.entity_index) < MAX_USERS);
        end
        MODE_LOAD_ITEM: begin
          i_we = dim_ok && (32'(in_data.entity_index) < MAX_ITEMS);
        end
        MODE_QUERY: begin
          is_query = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign u_raddr  = ubase + UA_W'(k);
  assign i_raddr  = ibase + IA_W'(k);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd_valid    <= 1'b0;
      out_valid   <= 1'b0;
      rank_in_use <= RANK_RESET;
    end else begin
      if (cfg_wr && paddr[CFG_ADDR_W-1] == REG_RANK) begin
        rank_in_use <= pwdata[RANK_CFG_W-1:0];
      end
      rd_valid <= (state == S_RUN);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (is_query) begin
            state <= (query_err || rank_eff == '0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (k == rank_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_valid && !mac_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (is_query) begin
      k         <= '0;
      rank_last <= K_W'(rank_m1);
      err       <= query_err;
      ubase     <= UA_W'(32'(in_data.user_index) * 32'(MAX_RANK));
      ibase     <= IA_W'(32'(in_data.item_index) * 32'(MAX_RANK));
    end else if (state == S_RUN) begin
      k <= k + 1'b1;
    end
    if (out_load) begin
      out_data.prediction  <= mac_result;
      out_data.index_error <= err;
    end
  end

  // The accumulator is cleared on every query, so error and rank-zero
  // results come out as zero without a separate path.
  assign mac_ctrl.clear = is_query;
  assign mac_ctrl.valid = rd_valid;

  lfdp_factor_ram #(
    .DEPTH  (U_DEPTH),
    .ADDR_W (UA_W)
  ) u_user_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (in_data.factor_value),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  lfdp_factor_ram #(
    .DEPTH  (I_DEPTH),
    .ADDR_W (IA_W)
  ) u_item_ram (
    .clk   (clk),
    .we    (i_we),
    .waddr (i_waddr),
    .wdata (in_data.factor_value),
    .raddr (i_raddr),
    .rdata (i_rdata)
  );

  lfdp_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a      (u_rdata),
    .b      (i_rdata),
    .result (mac_result),
    .busy   (mac_busy)
  );

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.index_error |-> out_data.prediction == '0)
    else $error("index error result carries a nonzero prediction");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !rd_valid && !mac_busy)
    else $error("datapath still busy while the sequencer is idle");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_accept && !is_query && !out_valid |=> !out_valid)
    else $error("a non-query beat produced a result");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> k <= rank_last)
    else $error("dimension counter ran past the rank");
`endif

endmodule : latent_factor_dot_product
`default_nettype wire

FILE: bench/dot_product_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dot_product_checker
// Watches the configuration port and both beat channels of the latent factor
// dot product block. It keeps its own copy of the factor stores and the rank
// setting, works out the prediction of every accepted query and compares
// each accepted result, field by field, with the oldest prediction waiting.
// ----------------------------------------------------------------------------
module dot_product_checker
  import lfdp_pkg::*;
#(
  parameter int MAX_USERS = 1024,
  parameter int MAX_ITEMS = 1024,
  parameter int MAX_RANK  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  output int                    mismatch_count,
  output int                    awaited,
  output int                    results_checked
);

  localparam int PRINT_LIMIT = 100;

  logic signed [FACTOR_W-1:0] user_store [MAX_USERS*MAX_RANK];
  logic signed [FACTOR_W-1:0] item_store [MAX_ITEMS*MAX_RANK];
  logic [RANK_CFG_W-1:0]      rank_setting;
  out_item_t                  predictions [$];

  initial begin
    mismatch_count  = 0;
    awaited         = 0;
    results_checked = 0;
    rank_setting    = RANK_RESET;
    foreach (user_store[n]) user_store[n] = '0;
    foreach (item_store[n]) item_store[n] = '0;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic out_item_t predict_dot(input logic [9:0] user, input logic [9:0] item);
    out_item_t                  res;
    logic signed [ACC_W-1:0]    acc;
    int unsigned                rank;
    int unsigned                ubase;
    int unsigned                ibase;
    res.prediction  = '0;
    res.index_error = 1'b0;
    if (user >= MAX_USERS || item >= MAX_ITEMS) begin
      res.index_error = 1'b1;
      return res;
    end
    // Settings above the store depth fall back to the full depth.
    rank  = (rank_setting > MAX_RANK) ? MAX_RANK : rank_setting;
    ubase = user * MAX_RANK;
    ibase = item * MAX_RANK;
    acc   = '0;
    for (int unsigned k = 0; k < rank; k++) begin
      acc += user_store[ubase + k] * item_store[ibase + k];
    end
    if (acc > PRED_MAX) acc = PRED_MAX;
    if (acc < PRED_MIN) acc = PRED_MIN;
    res.prediction = acc[PRED_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      rank_setting = RANK_RESET;
      predictions.delete();
      awaited <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1] == REG_RANK) begin
        rank_setting = pwdata[RANK_CFG_W-1:0];
      end

      // Results leave before new beats enter, so a beat accepted at this edge
      // never answers a result taken at the same edge.
      if (out_valid && !out_stall) begin
        if (predictions.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited: prediction %0d error %0b",
                                    out_data.prediction, out_data.index_error));
        end else begin
          want = predictions.pop_front();
          results_checked++;
          if (out_data.prediction !== want.prediction) begin
            report_mismatch($sformatf("prediction %0d, expected %0d",
                                      out_data.prediction, want.prediction));
          end
          if (out_data.index_error !== want.index_error) begin
            report_mismatch($sformatf("index_error %0b, expected %0b",
                                      out_data.index_error, want.index_error));
          end
        end
      end

      if (in_valid && !in_stall) begin
        case (in_data.mode)
          MODE_LOAD_USER: begin
            if (in_data.entity_index < MAX_USERS && in_data.dimension_index < MAX_RANK) begin
              user_store[in_data.entity_index * MAX_RANK + in_data.dimension_index] =
                in_data.factor_value;
            end
          end
          MODE_LOAD_ITEM: begin
            if (in_data.entity_index < MAX_ITEMS && in_data.dimension_index < MAX_RANK) begin
              item_store[in_data.entity_index * MAX_RANK + in_data.dimension_index] =
                in_data.factor_value;
            end
          end
          MODE_QUERY: begin
            predictions.push_back(predict_dot(in_data.user_index, in_data.item_index));
          end
          default: begin
          end
        endcase
      end

      awaited <= predictions.size();
    end
  end

endmodule : dot_product_checker
`default_nettype wire

FILE: bench/tb_latent_factor_dot_product.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_latent_factor_dot_product
// Drives load, query and unused-mode beats into the latent factor dot product
// block under random idling on both channels, across several rank settings,
// and reports the verdict from the checker's mismatch count and the results still awaited.
// ----------------------------------------------------------------------------
module tb_latent_factor_dot_product;
  import lfdp_pkg::*;

  localparam int MAX_USERS     = 1024;
  localparam int MAX_ITEMS     = 1024;
  localparam int MAX_RANK      = 32;
  localparam int SETTLE_CYCLES = MAX_RANK + 8;
  localparam int PHASE_BEATS   = 175;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  int mismatch_count;
  int awaited;
  int results_checked;

  logic calm = 1'b0;
  int   stall_left = 0;
  int   beats_sent = 0;
  int   rank_settings_used = 0;

  // Which dimensions of each vector have been written, so that a query never
  // reads an entry that was never loaded.
  logic [MAX_RANK-1:0] user_dims [MAX_USERS] = '{default: '0};
  logic [MAX_RANK-1:0] item_dims [MAX_ITEMS] = '{default: '0};
  bit                  user_full [MAX_USERS];
  bit                  item_full [MAX_ITEMS];
  int                  full_users [$];
  int                  full_items [$];

  latent_factor_dot_product #(
    .MAX_USERS(MAX_USERS),
    .MAX_ITEMS(MAX_ITEMS),
    .MAX_RANK (MAX_RANK)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  dot_product_checker #(
    .MAX_USERS(MAX_USERS),
    .MAX_ITEMS(MAX_ITEMS),
    .MAX_RANK (MAX_RANK)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .awaited        (awaited),
    .results_checked(results_checked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #16_000_000;
    $display("Timed out with %0d results still awaited.", awaited);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      out_stall  <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic signed [FACTOR_W-1:0] random_factor();
    int          r;
    logic [31:0] raw;
    r   = $urandom_range(0, 99);
    raw = $urandom();
    if (r < 10) return 16'sh8000;
    if (r < 20) return 16'sh7FFF;
    if (r < 25) return '0;
    if (r < 30) return raw[0] ? 16'sh0001 : 16'shFFFF;
    return raw[FACTOR_W-1:0];
  endfunction

  // Fields that the mode does not use still carry random values.
  function automatic in_item_t random_beat();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic send_beat(input in_item_t beat);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    // The valid stays high across back-to-back beats.
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_load(input logic [1:0] mode, input int entity, input int dim,
                           input logic signed [FACTOR_W-1:0] value);
    in_item_t beat;
    beat                 = random_beat();
    beat.mode            = mode;
    beat.entity_index    = 10'(entity);
    beat.dimension_index = 5'(dim);
    beat.factor_value    = value;
    if (mode == MODE_LOAD_USER) begin
      user_dims[entity][dim] = 1'b1;
      if (&user_dims[entity] && !user_full[entity]) begin
        user_full[entity] = 1'b1;
        full_users.push_back(entity);
      end
    end else begin
      item_dims[entity][dim] = 1'b1;
      if (&item_dims[entity] && !item_full[entity]) begin
        item_full[entity] = 1'b1;
        full_items.push_back(entity);
      end
    end
    send_beat(beat);
  endtask

  task automatic send_query(input int user, input int item);
    in_item_t beat;
    beat            = random_beat();
    beat.mode       = MODE_QUERY;
    beat.user_index = 10'(user);
    beat.item_index = 10'(item);
    send_beat(beat);
  endtask

  task automatic send_noise();
    in_item_t beat;
    beat      = random_beat();
    beat.mode = MODE_UNUSED;
    send_beat(beat);
  endtask

  // A whole vector, one beat per dimension; some vectors sit at the extremes
  // so that the sums reach their largest magnitudes.
  task automatic load_vector(input logic [1:0] mode, input int entity);
    int                         style;
    logic signed [FACTOR_W-1:0] value;
    style = $urandom_range(0, 9);
    for (int d = 0; d < MAX_RANK; d++) begin
      if (style == 0) value = 16'sh8000;
      else if (style == 1) value = (mode == MODE_LOAD_USER) ? 16'sh7FFF : 16'sh8000;
      else value = random_factor();
      send_load(mode, entity, d, value);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    // A load in flight produces no result, so give the block time to settle.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rank(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_RANK, {(CFG_ADDR_W-1){1'b0}}};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rank_settings_used++;
  endtask

  task automatic run_phase(input int unsigned rank_value, input logic quiet);
    int start;
    int pick;
    int user;
    int item;
    drain_results();
    write_rank(rank_value);
    calm  <= quiet;
    start = beats_sent;
    while (beats_sent - start < PHASE_BEATS) begin
      pick = $urandom_range(0, 99);
      if (full_users.size() == 0 || pick < 5) begin
        load_vector(MODE_LOAD_USER, $urandom_range(0, MAX_USERS - 1));
      end else if (full_items.size() == 0 || pick < 10) begin
        load_vector(MODE_LOAD_ITEM, $urandom_range(0, MAX_ITEMS - 1));
      end else if (pick < 18) begin
        if ($urandom_range(0, 1)) begin
          send_load(MODE_LOAD_ITEM, $urandom_range(0, MAX_ITEMS - 1),
                    $urandom_range(0, MAX_RANK - 1), random_factor());
        end else begin
          send_load(MODE_LOAD_USER, $urandom_range(0, MAX_USERS - 1),
                    $urandom_range(0, MAX_RANK - 1), random_factor());
        end
      end else if (pick < 22) begin
        send_noise();
      end else if (pick < 23) begin
        drain_results();
      end else begin
        // With rank zero nothing is read, so any pair of indices may be asked.
        if (rank_value == 0) begin
          user = $urandom_range(0, MAX_USERS - 1);
          item = $urandom_range(0, MAX_ITEMS - 1);
        end else begin
          user = full_users[$urandom_range(0, full_users.size() - 1)];
          item = full_items[$urandom_range(0, full_items.size() - 1)];
        end
        send_query(user, item);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-dimension vectors at the extremes of the factor range and of
    // both index fields.
    write_rank(1);
    send_load(MODE_LOAD_USER, 0, 0, 16'sh8000);
    send_load(MODE_LOAD_ITEM, 0, 0, 16'sh8000);
    send_query(0, 0);
    send_load(MODE_LOAD_USER, MAX_USERS - 1, 0, 16'sh7FFF);
    send_load(MODE_LOAD_ITEM, MAX_ITEMS - 1, 0, 16'sh8000);
    send_query(MAX_USERS - 1, 0);
    send_query(0, MAX_ITEMS - 1);
    send_query(MAX_USERS - 1, MAX_ITEMS - 1);
    send_beat('1);
    send_load(MODE_LOAD_USER, MAX_USERS - 1, MAX_RANK - 1, '0);
    send_load(MODE_LOAD_ITEM, 0, MAX_RANK - 1, 16'sh7FFF);
    send_query(MAX_USERS - 1, MAX_ITEMS - 1);

    // Rank zero sums nothing, whatever the indices.
    drain_results();
    write_rank(0);
    send_query(MAX_USERS - 1, MAX_ITEMS - 1);
    send_query(512, 511);

    run_phase(32, 1'b0);
    run_phase(63, 1'b0);
    run_phase($urandom_range(2, MAX_RANK - 1), 1'b1);
    run_phase(0, 1'b0);
    run_phase(1, 1'b0);
    run_phase(32, 1'b0);

    drain_results();
    $display("Covered %0d input beats of all four modes and %0d checked query results,",
             beats_sent, results_checked);
    $display("under %0d rank settings from 0 to 63 with random idling on both channels.",
             rank_settings_used);
    if (mismatch_count == 0 && awaited == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : tb_latent_factor_dot_product
`default_nettype wire
